@@ design/websocket_frame_deframer_assert.svh @@
// Assertion macros used by the deframer queue module.
`ifndef WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH
`define WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define WSD_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("wsd assertion failed");
// Next-cycle implication, checked out of reset.
`define WSD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wsd assertion failed");
`else
`define WSD_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define WSD_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

@@ design/wsd_pkg.sv @@
`timescale 1ns / 1ps
package wsd_pkg;

   // Width of the payload length counter; longer lengths wrap.
   localparam int LENGTH_BITS = 32;

   // Depth of the queue between front and back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // Frame opcodes of interest.
   localparam logic [3:0] OP_TEXT  = 4'h1;
   localparam logic [3:0] OP_CLOSE = 4'h8;
   localparam logic [3:0] OP_PING  = 4'h9;

   // Result kinds.
   localparam logic [1:0] KIND_TEXT  = 2'd0;
   localparam logic [1:0] KIND_PING  = 2'd1;
   localparam logic [1:0] KIND_CLOSE = 2'd2;

   // One classified result on its way to the back part.
   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
      logic       has_data;
      logic       frame_last;
      logic       masked;
      logic [7:0] key_byte;
   } wsd_item_type;

endpackage

@@ design/wsd_front.sv @@
`timescale 1ns / 1ps
module wsd_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          rx_byte,
   output logic                push,
   output wsd_pkg::wsd_item_type item
);
   import wsd_pkg::*;

   // Parse phases
   localparam logic [2:0] PH_HDR0 = 3'd0;
   localparam logic [2:0] PH_HDR1 = 3'd1;
   localparam logic [2:0] PH_EXT  = 3'd2;
   localparam logic [2:0] PH_KEY  = 3'd3;
   localparam logic [2:0] PH_DATA = 3'd4;

   logic [2:0]             phase_ff, phase_in;
   logic [3:0]             opcode_ff, opcode_in;
   logic                   masked_ff, masked_in;
   logic [2:0]             ext_cnt_ff, ext_cnt_in;
   logic [LENGTH_BITS-1:0] remain_ff, remain_in;
   logic [31:0]            key_ff, key_in;
   logic [1:0]             idx_ff, idx_in;

   logic                   end_len, end_hdr, mask_sel, last;
   logic [LENGTH_BITS-1:0] len_val;
   logic [7:0]             key_sel;

   // Key byte for the next payload byte, first key byte first
   always_comb begin
      case (idx_ff)
         2'd0:    key_sel = key_ff[31:24];
         2'd1:    key_sel = key_ff[23:16];
         2'd2:    key_sel = key_ff[15:8];
         default: key_sel = key_ff[7:0];
      endcase
   end

   // Header parser and payload classifier
   always_comb begin
      phase_in   = phase_ff;
      opcode_in  = opcode_ff;
      masked_in  = masked_ff;
      ext_cnt_in = ext_cnt_ff;
      remain_in  = remain_ff;
      key_in     = key_ff;
      idx_in     = idx_ff;
      end_len    = 1'b0;
      end_hdr    = 1'b0;
      mask_sel   = masked_ff;
      len_val    = remain_ff;
      last       = 1'b0;
      push       = 1'b0;
      item       = '0;
      item.masked   = masked_ff;
      item.key_byte = key_sel;

      if (accept) begin
         case (phase_ff)
            PH_HDR1: begin
               mask_sel  = rx_byte[7];
               masked_in = rx_byte[7];
               key_in    = '0;
               idx_in    = '0;
               remain_in = '0;
               if (rx_byte[6:0] == 7'd126) begin
                  ext_cnt_in = 3'd1;
                  phase_in   = PH_EXT;
               end else if (rx_byte[6:0] == 7'd127) begin
                  ext_cnt_in = 3'd7;
                  phase_in   = PH_EXT;
               end else begin
                  len_val   = {{(LENGTH_BITS-7){1'b0}}, rx_byte[6:0]};
                  remain_in = len_val;
                  end_len   = 1'b1;
               end
            end
            PH_EXT: begin
               len_val   = {remain_ff[LENGTH_BITS-9:0], rx_byte};
               remain_in = len_val;
               if (ext_cnt_ff == 3'd0) begin
                  end_len = 1'b1;
               end else begin
                  ext_cnt_in = ext_cnt_ff - 3'd1;
               end
            end
            PH_KEY: begin
               key_in = {key_ff[23:0], rx_byte};
               if (idx_ff == 2'd3) begin
                  idx_in  = '0;
                  end_hdr = 1'b1;
               end else begin
                  idx_in = idx_ff + 2'd1;
               end
            end
            PH_DATA: begin
               idx_in    = idx_ff + 2'd1;
               remain_in = remain_ff - {{(LENGTH_BITS-1){1'b0}}, 1'b1};
               last      = (remain_in == '0);
               if (last) begin
                  phase_in = PH_HDR0;
               end
               item.frame_last = last;
               if (opcode_ff == OP_TEXT || opcode_ff == OP_PING) begin
                  push          = 1'b1;
                  item.kind     = (opcode_ff == OP_TEXT) ? KIND_TEXT : KIND_PING;
                  item.data     = rx_byte;
                  item.has_data = 1'b1;
               end else if (opcode_ff == OP_CLOSE && last) begin
                  push      = 1'b1;
                  item.kind = KIND_CLOSE;
               end
            end
            default: begin
               opcode_in = rx_byte[3:0];
               phase_in  = PH_HDR1;
            end
         endcase

         // Length complete: take the key next, or close the header
         if (end_len) begin
            if (mask_sel) begin
               phase_in = PH_KEY;
               idx_in   = '0;
            end else begin
               end_hdr = 1'b1;
            end
         end

         // Header complete: payload follows, or an empty frame ends here
         if (end_hdr) begin
            if (len_val != '0) begin
               phase_in = PH_DATA;
            end else begin
               phase_in        = PH_HDR0;
               item.frame_last = 1'b1;
               if (opcode_ff == OP_TEXT) begin
                  push      = 1'b1;
                  item.kind = KIND_TEXT;
               end else if (opcode_ff == OP_PING) begin
                  push      = 1'b1;
                  item.kind = KIND_PING;
               end else if (opcode_ff == OP_CLOSE) begin
                  push      = 1'b1;
                  item.kind = KIND_CLOSE;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HDR0;
         opcode_ff  <= '0;
         masked_ff  <= 1'b0;
         ext_cnt_ff <= '0;
         remain_ff  <= '0;
         key_ff     <= '0;
         idx_ff     <= '0;
      end else begin
         phase_ff   <= phase_in;
         opcode_ff  <= opcode_in;
         masked_ff  <= masked_in;
         ext_cnt_ff <= ext_cnt_in;
         remain_ff  <= remain_in;
         key_ff     <= key_in;
         idx_ff     <= idx_in;
      end
   end

endmodule

@@ design/wsd_queue.sv @@
`timescale 1ns / 1ps
`include "websocket_frame_deframer_assert.svh"
module wsd_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  wsd_pkg::wsd_item_type push_item,
   input  logic                 pop,
   output logic                 full,
   output logic                 not_empty,
   output wsd_pkg::wsd_item_type head_item
);
   import wsd_pkg::*;

   wsd_item_type         slot_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0] count_ff, count_in;

   assign full      = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_item = slot_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   `WSD_ASSERT_IMPL(a_no_push_full, clock, reset, full, !push)
   `WSD_ASSERT_IMPL(a_no_pop_empty, clock, reset, !not_empty, !pop)
   `WSD_ASSERT_NEXT(a_fill_grows, clock, reset, push && !pop, count_ff == $past(count_ff) + 1'b1)
   `WSD_ASSERT_IMPL(a_ptrs_agree, clock, reset, count_ff == '0, wr_ptr_ff == rd_ptr_ff)

endmodule

@@ design/wsd_back.sv @@
`timescale 1ns / 1ps
module wsd_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  wsd_pkg::wsd_item_type in_item,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [1:0]           rsp_kind,
   output logic [7:0]           rsp_out_byte,
   output logic                 rsp_has_data,
   output logic                 rsp_frame_last
);
   import wsd_pkg::*;

   logic       valid_ff, valid_in;
   logic [1:0] kind_ff;
   logic [7:0] byte_ff, byte_in;
   logic       has_ff, last_ff;

   // Load the output register when it is empty or being drained
   assign pop      = in_valid && (!valid_ff || !rsp_stall);
   assign valid_in = pop ? 1'b1 : (valid_ff && rsp_stall);

   // Unmask the payload byte
   always_comb begin
      byte_in = '0;
      if (in_item.has_data) begin
         byte_in = in_item.masked ? (in_item.data ^ in_item.key_byte) : in_item.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         kind_ff <= in_item.kind;
         byte_ff <= byte_in;
         has_ff  <= in_item.has_data;
         last_ff <= in_item.frame_last;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_kind       = kind_ff;
   assign rsp_out_byte   = byte_ff;
   assign rsp_has_data   = has_ff;
   assign rsp_frame_last = last_ff;

endmodule

@@ design/websocket_frame_deframer.sv @@
`timescale 1ns / 1ps
// Channel   Ports                                                                       Dir
// request   req_valid, req_stall, req_rx_byte                                           in
// response  rsp_valid, rsp_stall, rsp_kind, rsp_out_byte, rsp_has_data, rsp_frame_last  out
//
// One byte is taken per cycle while req_stall is low; the header parser state is registered.
// A result is registered first in the queue, then in the output register; rsp_stall can hold it in either.
// req_stall rises only while the four-entry queue is full.
// Reset is synchronous; it returns the parser to the first header byte and empties the queue.
module websocket_frame_deframer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_has_data,
   output logic       rsp_frame_last
);
   import wsd_pkg::*;

   logic         accept, push, pop, q_full, q_not_empty;
   wsd_item_type push_item, head_item;

   // Input transfer
   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   wsd_front u_front (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .rx_byte (req_rx_byte),
      .push    (push),
      .item    (push_item)
   );

   wsd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head_item (head_item)
   );

   wsd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (q_not_empty),
      .in_item        (head_item),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_has_data   (rsp_has_data),
      .rsp_frame_last (rsp_frame_last)
   );

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
   import wsd_pkg::*;

   localparam int DIRECTED_ROWS = 25;
   localparam int RANDOM_ITEMS  = 400;
   localparam int PAUSE_AT      = DIRECTED_ROWS + 220;
   localparam int HOLD_CYCLES   = 60;
   localparam int CYCLE_LIMIT   = 300000;

   typedef enum logic [2:0] {PH_HDR0, PH_HDR1, PH_EXT, PH_KEY, PH_DATA} deframe_phase_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] out_byte;
      logic       has_data;
      logic       frame_last;
   } frame_rsp_type;

   typedef struct packed {
      logic [7:0]    rx;
      logic          typed;
      frame_rsp_type want;
   } stim_row_type;

   localparam frame_rsp_type NO_RSP = '0;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_rx_byte;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [1:0] rsp_kind;
   logic [7:0] rsp_out_byte;
   logic       rsp_has_data;
   logic       rsp_frame_last;

   websocket_frame_deframer u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_rx_byte   (req_rx_byte),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_kind      (rsp_kind),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_has_data  (rsp_has_data),
      .rsp_frame_last(rsp_frame_last)
   );

   // Directed stream: empty frames, masked and unmasked payload, skipped opcode,
   // 16-bit extended length. Expected results typed in where obvious.
   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      // empty text, unmasked
      '{8'h81, 1'b0, NO_RSP},
      '{8'h00, 1'b1, '{KIND_TEXT, 8'h00, 1'b0, 1'b1}},
      // empty ping, masked
      '{8'h89, 1'b0, NO_RSP},
      '{8'h80, 1'b0, NO_RSP},
      '{8'hFF, 1'b0, NO_RSP},
      '{8'h00, 1'b0, NO_RSP},
      '{8'hFF, 1'b0, NO_RSP},
      '{8'h00, 1'b1, '{KIND_PING, 8'h00, 1'b0, 1'b1}},
      // empty close
      '{8'h88, 1'b0, NO_RSP},
      '{8'h00, 1'b1, '{KIND_CLOSE, 8'h00, 1'b0, 1'b1}},
      // masked text, one byte: 5A ^ A5
      '{8'h81, 1'b0, NO_RSP},
      '{8'h81, 1'b0, NO_RSP},
      '{8'hA5, 1'b0, NO_RSP},
      '{8'h00, 1'b0, NO_RSP},
      '{8'h00, 1'b0, NO_RSP},
      '{8'h00, 1'b0, NO_RSP},
      '{8'h5A, 1'b1, '{KIND_TEXT, 8'hFF, 1'b1, 1'b1}},
      // binary frame, skipped silently
      '{8'h82, 1'b0, NO_RSP},
      '{8'h01, 1'b0, NO_RSP},
      '{8'hAB, 1'b0, NO_RSP},
      // text with 16-bit extended length of one, FIN clear
      '{8'h01, 1'b0, NO_RSP},
      '{8'h7E, 1'b0, NO_RSP},
      '{8'h00, 1'b0, NO_RSP},
      '{8'h01, 1'b0, NO_RSP},
      '{8'h41, 1'b1, '{KIND_TEXT, 8'h41, 1'b1, 1'b1}}
   };

   stim_row_type  rx_stream [$];
   frame_rsp_type rsp_expect [$];
   int            fail_count = 0;
   int            fed_count = 0;
   int            taken_count = 0;
   int            cycle_count = 0;

   // Parser state mirror
   deframe_phase_type      pr_phase = PH_HDR0;
   logic [3:0]             pr_opcode = '0;
   logic                   pr_masked = 1'b0;
   logic [2:0]             pr_ext_left = '0;
   logic [LENGTH_BITS-1:0] pr_remaining = '0;
   logic [31:0]            pr_key = '0;
   logic [1:0]             pr_key_idx = '0;

   task automatic report_error(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      fail_count++;
   endtask

   // Header complete: go to payload or finish an empty frame.
   function automatic bit close_header(output frame_rsp_type r);
      r = NO_RSP;
      if (pr_remaining != 0) begin
         pr_phase = PH_DATA;
         return 1'b0;
      end
      pr_phase = PH_HDR0;
      case (pr_opcode)
         OP_TEXT:  r.kind = KIND_TEXT;
         OP_PING:  r.kind = KIND_PING;
         OP_CLOSE: r.kind = KIND_CLOSE;
         default:  return 1'b0;
      endcase
      r.frame_last = 1'b1;
      return 1'b1;
   endfunction

   // Length complete: take a mask key if present.
   function automatic bit close_length(output frame_rsp_type r);
      r = NO_RSP;
      if (pr_masked) begin
         pr_phase = PH_KEY;
         pr_key_idx = '0;
         return 1'b0;
      end
      return close_header(r);
   endfunction

   // Advance the mirror by one byte; returns 1 when the byte yields a result.
   function automatic bit deframe_byte(input logic [7:0] b, output frame_rsp_type r);
      logic [7:0] v;
      logic       last;
      r = NO_RSP;
      case (pr_phase)
         PH_HDR1: begin
            pr_masked = b[7];
            pr_key = '0;
            pr_key_idx = '0;
            pr_remaining = '0;
            if (b[6:0] == 7'd126) begin
               pr_ext_left = 3'd1;
               pr_phase = PH_EXT;
               return 1'b0;
            end
            if (b[6:0] == 7'd127) begin
               pr_ext_left = 3'd7;
               pr_phase = PH_EXT;
               return 1'b0;
            end
            pr_remaining = LENGTH_BITS'(b[6:0]);
            return close_length(r);
         end
         PH_EXT: begin
            pr_remaining = (pr_remaining << 8) | LENGTH_BITS'(b);
            if (pr_ext_left == 0) return close_length(r);
            pr_ext_left = pr_ext_left - 3'd1;
            return 1'b0;
         end
         PH_KEY: begin
            pr_key = {pr_key[23:0], b};
            if (pr_key_idx == 2'd3) begin
               pr_key_idx = '0;
               return close_header(r);
            end
            pr_key_idx = pr_key_idx + 2'd1;
            return 1'b0;
         end
         PH_DATA: begin
            v = pr_masked ? (b ^ pr_key[8 * (3 - pr_key_idx) +: 8]) : b;
            pr_key_idx = pr_key_idx + 2'd1;
            pr_remaining = pr_remaining - 1'b1;
            last = (pr_remaining == 0);
            if (last) pr_phase = PH_HDR0;
            case (pr_opcode)
               OP_TEXT:  r = '{KIND_TEXT, v, 1'b1, last};
               OP_PING:  r = '{KIND_PING, v, 1'b1, last};
               OP_CLOSE: begin
                  if (!last) return 1'b0;
                  r = '{KIND_CLOSE, 8'h00, 1'b0, 1'b1};
               end
               default:  return 1'b0;
            endcase
            return 1'b1;
         end
         default: begin
            pr_opcode = b[3:0];
            pr_phase = PH_HDR1;
            return 1'b0;
         end
      endcase
   endfunction

   task automatic add_byte(input logic [7:0] b);
      rx_stream.push_back('{b, 1'b0, NO_RSP});
   endtask

   // One random frame: mostly text/ping/close, some arbitrary opcodes;
   // 7-bit, 16-bit or 64-bit length (upper half random, wraps away).
   task automatic add_frame();
      int          pick;
      int          len_sel;
      logic [7:0]  hdr0;
      logic        masked;
      logic [31:0] len;
      pick = $urandom_range(0, 99);
      len_sel = $urandom_range(0, 9);
      masked = 1'($urandom_range(0, 1));
      hdr0 = 8'($urandom_range(0, 255));
      if (pick < 40) hdr0[3:0] = OP_TEXT;
      else if (pick < 60) hdr0[3:0] = OP_PING;
      else if (pick < 75) hdr0[3:0] = OP_CLOSE;
      add_byte(hdr0);
      if (len_sel < 7) begin
         len = (len_sel == 6) ? $urandom_range(0, 125) : $urandom_range(0, 8);
         add_byte({masked, len[6:0]});
      end else if (len_sel < 9) begin
         len = (len_sel == 8) ? $urandom_range(0, 300) : $urandom_range(0, 10);
         add_byte({masked, 7'd126});
         add_byte(len[15:8]);
         add_byte(len[7:0]);
      end else begin
         len = $urandom_range(0, 10);
         add_byte({masked, 7'd127});
         repeat (4) add_byte(8'($urandom_range(0, 255)));
         for (int k = 3; k >= 0; k--) add_byte(len[8 * k +: 8]);
      end
      if (masked) repeat (4) add_byte(8'($urandom_range(0, 255)));
      repeat (len) add_byte(8'($urandom_range(0, 255)));
   endtask

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end
   end

   // Result checker: compare every transfer against the oldest expectation
   always @(posedge clock) begin
      frame_rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         taken_count <= taken_count + 1;
         if (rsp_expect.size() == 0) begin
            report_error($sformatf("result with none expected: kind %0d byte %02h",
                                   rsp_kind, rsp_out_byte));
         end else begin
            want = rsp_expect.pop_front();
            if (rsp_kind !== want.kind)
               report_error($sformatf("kind %0d, want %0d", rsp_kind, want.kind));
            if (rsp_out_byte !== want.out_byte)
               report_error($sformatf("out_byte %02h, want %02h", rsp_out_byte,
                                      want.out_byte));
            if (rsp_has_data !== want.has_data)
               report_error($sformatf("has_data %0b, want %0b", rsp_has_data,
                                      want.has_data));
            if (rsp_frame_last !== want.frame_last)
               report_error($sformatf("frame_last %0b, want %0b", rsp_frame_last,
                                      want.frame_last));
         end
      end
   end

   // Receiver: random stall per transfer, bursts without stall, one long hold-off
   initial begin
      int stall_len;
      bit held_off;
      held_off = 1'b0;
      rsp_stall = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall_len = ((taken_count / 48) % 3 == 2) ? 0 : $urandom_range(0, 15);
         if (!held_off && fed_count >= DIRECTED_ROWS + 2) begin
            stall_len = HOLD_CYCLES;
            held_off = 1'b1;
         end
         if (stall_len > 0) begin
            rsp_stall <= 1'b1;
            repeat (stall_len) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (rsp_valid !== 1'b1) @(posedge clock);
         @(negedge clock);
      end
   end

   // Sender and run control
   initial begin
      int            gap;
      bit            burst;
      bit            has_rsp;
      frame_rsp_type got;
      stim_row_type  row;

      reset = 1'b1;
      req_valid = 1'b0;
      req_rx_byte = 8'h00;

      // Stimulus: directed rows, a long text frame for back-pressure, random frames
      foreach (directed_rows[i]) rx_stream.push_back(directed_rows[i]);
      add_byte(8'h81);
      add_byte(8'd40);
      repeat (40) add_byte(8'($urandom_range(0, 255)));
      while (rx_stream.size() < DIRECTED_ROWS + RANDOM_ITEMS) add_frame();

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (rx_stream[idx]) begin
         row = rx_stream[idx];
         burst = (idx >= DIRECTED_ROWS && idx < DIRECTED_ROWS + 42) || ((idx / 64) % 3 == 1);
         gap = burst ? 0 : $urandom_range(0, 15);
         if (idx == PAUSE_AT) begin
            // drain everything before going on
            req_valid <= 1'b0;
            @(negedge clock);
            while (rsp_expect.size() != 0) @(negedge clock);
         end else if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         req_valid <= 1'b1;
         req_rx_byte <= row.rx;
         @(posedge clock);
         while (req_stall) @(posedge clock);
         // transfer taken: advance the mirror and record the expectation
         has_rsp = deframe_byte(row.rx, got);
         if (row.typed) rsp_expect.push_back(row.want);
         else if (has_rsp) rsp_expect.push_back(got);
         fed_count++;
         @(negedge clock);
      end
      req_valid <= 1'b0;

      while (rsp_expect.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);

      if (fail_count == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule

@@ websocket_frame_deframer.f @@
+incdir+design
design/wsd_pkg.sv
design/wsd_front.sv
design/wsd_queue.sv
design/wsd_back.sv
design/websocket_frame_deframer.sv
tb/tb_top.sv
